>>> rtl/core/spwq_pkg.sv
`default_nettype none

package spwq_pkg;

  // Fixed widths of the request and response words
  localparam int PORT_HANDLE_W = 32;
  localparam int PORT_PRIO_W   = 2;
  localparam int MAX_HANDLE_W  = 64;
  localparam int MAX_LEVEL_W   = 4;

  // Request type codes
  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2,
    ST_EMPTY   = 2'd3
  } spwq_status_t;

  // Operation decided by the front end
  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_SKIP = 2'd1,
    OP_POP  = 2'd2
  } spwq_op_t;

  typedef struct packed {
    spwq_op_t                   op;
    logic [MAX_LEVEL_W-1:0]     level;
    logic [PORT_HANDLE_W-1:0]   handle;
  } spwq_cmd_t;

  typedef struct packed {
    logic                       found;
    logic [PORT_HANDLE_W-1:0]   handle;
    logic [PORT_PRIO_W-1:0]     level;
    spwq_status_t               status;
  } spwq_rsp_t;

endpackage

`default_nettype wire

>>> rtl/core/spwq_if.sv
`default_nettype none

// Request channel: one push or pop request per word
interface spwq_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [1:0]  push_priority;
  logic [31:0] push_handle;
  logic        push_valid;

  modport source (output valid, req_type, push_priority, push_handle, push_valid,
                  input ready);
  modport sink   (input valid, req_type, push_priority, push_handle, push_valid,
                  output ready);
endinterface

// Response channel: one result word per request
interface spwq_rsp_if;
  logic        valid;
  logic        ready;
  logic        pop_found;
  logic [31:0] pop_handle;
  logic [1:0]  pop_priority;
  logic [1:0]  status;

  modport source (output valid, pop_found, pop_handle, pop_priority, status,
                  input ready);
  modport sink   (input valid, pop_found, pop_handle, pop_priority, status,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/core/spwq_ram.sv
`default_nettype none

module spwq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/spwq_front.sv
`default_nettype none

module spwq_front #(
  parameter int NUM_LEVELS = 4
) (
  input  wire logic                clk,
  input  wire logic                rst,
  spwq_req_if.sink                 req,
  output logic                     cmd_valid,
  input  wire logic                cmd_ready,
  output spwq_pkg::spwq_cmd_t      cmd
);

  localparam int CMP_W = spwq_pkg::MAX_LEVEL_W + 1;

  spwq_pkg::spwq_cmd_t entries [2];
  logic                wr_ptr;
  logic                rd_ptr;
  logic [1:0]          count;
  spwq_pkg::spwq_cmd_t new_cmd;
  logic                push;
  logic                pop;

  // Classify the incoming word and saturate the level
  always_comb begin
    new_cmd.handle = req.push_handle;
    if (CMP_W'(req.push_priority) >= CMP_W'(NUM_LEVELS)) begin
      new_cmd.level = spwq_pkg::MAX_LEVEL_W'(NUM_LEVELS - 1);
    end else begin
      new_cmd.level = spwq_pkg::MAX_LEVEL_W'(req.push_priority);
    end
    if (req.req_type == spwq_pkg::REQ_POP) begin
      new_cmd.op = spwq_pkg::OP_POP;
    end else if (req.push_valid) begin
      new_cmd.op = spwq_pkg::OP_PUSH;
    end else begin
      new_cmd.op = spwq_pkg::OP_SKIP;
    end
  end

  assign req.ready = (count != 2'd2);
  assign push      = req.valid && req.ready;
  assign cmd_valid = (count != 2'd0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = entries[rd_ptr];

  // Two-word command queue between front and back
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        entries[wr_ptr] <= new_cmd;
        wr_ptr          <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/spwq_back.sv
`default_nettype none

module spwq_back #(
  parameter int NUM_LEVELS   = 4,
  parameter int QUEUE_DEPTH  = 16,
  parameter int HANDLE_WIDTH = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cmd_valid,
  output logic                      cmd_ready,
  input  wire spwq_pkg::spwq_cmd_t  cmd,
  output logic                      rsp_valid,
  input  wire logic                 rsp_ready,
  output spwq_pkg::spwq_rsp_t       rsp_data
);

  localparam int LW      = $clog2(NUM_LEVELS);
  localparam int PW      = $clog2(QUEUE_DEPTH);
  localparam int CW      = $clog2(QUEUE_DEPTH + 1);
  localparam int ENTRIES = NUM_LEVELS * QUEUE_DEPTH;
  localparam int AW      = $clog2(ENTRIES);

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  state_t                  state;
  logic [PW-1:0]           head [NUM_LEVELS];
  logic [PW-1:0]           tail [NUM_LEVELS];
  logic [CW-1:0]           count [NUM_LEVELS];
  logic [LW-1:0]           sel_q;
  logic                    rsp_valid_q;
  spwq_pkg::spwq_rsp_t     rsp_q;

  logic                    take;
  logic                    rsp_load;
  logic [LW-1:0]           lvl;
  logic                    lvl_full;
  logic [LW-1:0]           sel;
  logic                    any;
  logic [PW-1:0]           tail_next;
  logic [PW-1:0]           head_next;
  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  logic [HANDLE_WIDTH-1:0] ram_wdata;
  logic                    ram_re;
  logic [AW-1:0]           ram_raddr;
  logic [HANDLE_WIDTH-1:0] ram_rdata;
  logic [spwq_pkg::MAX_HANDLE_W-1:0] wr_wide;
  logic [spwq_pkg::MAX_HANDLE_W-1:0] rd_wide;
  logic [spwq_pkg::MAX_LEVEL_W-1:0]  sel_wide;

  assign cmd_ready = (state == S_IDLE) && (!rsp_valid_q || rsp_ready);
  assign take      = cmd_valid && cmd_ready;
  assign lvl       = cmd.level[LW-1:0];
  assign lvl_full  = (count[lvl] == CW'(QUEUE_DEPTH));

  // Load a result word this cycle: read state, or any command but a pop that finds work
  assign rsp_load  = (state == S_READ) ||
                     (take && !((cmd.op == spwq_pkg::OP_POP) && any));

  // Pick the highest non-empty level
  always_comb begin
    sel = '0;
    any = 1'b0;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      if (count[i] != '0) begin
        sel = LW'(i);
        any = 1'b1;
      end
    end
  end

  // Advance pointers with wrap at the queue depth
  assign tail_next = (tail[lvl] == PW'(QUEUE_DEPTH - 1)) ? '0 : tail[lvl] + PW'(1);
  assign head_next = (head[sel] == PW'(QUEUE_DEPTH - 1)) ? '0 : head[sel] + PW'(1);

  // Handle store access
  assign wr_wide   = spwq_pkg::MAX_HANDLE_W'(cmd.handle);
  assign ram_wdata = wr_wide[HANDLE_WIDTH-1:0];
  assign ram_we    = take && (cmd.op == spwq_pkg::OP_PUSH) && !lvl_full;
  assign ram_waddr = AW'(32'(lvl) * 32'(QUEUE_DEPTH) + 32'(tail[lvl]));
  assign ram_re    = take && (cmd.op == spwq_pkg::OP_POP) && any;
  assign ram_raddr = AW'(32'(sel) * 32'(QUEUE_DEPTH) + 32'(head[sel]));
  assign rd_wide   = spwq_pkg::MAX_HANDLE_W'(ram_rdata);
  assign sel_wide  = spwq_pkg::MAX_LEVEL_W'(sel_q);

  spwq_ram #(
    .WIDTH (HANDLE_WIDTH),
    .DEPTH (ENTRIES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Execute commands, keep per-level pointers and the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      rsp_valid_q <= 1'b0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head[i]  <= '0;
        tail[i]  <= '0;
        count[i] <= '0;
      end
    end else begin
      if (rsp_ready && !rsp_load) begin
        rsp_valid_q <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (take) begin
            unique case (cmd.op)
              spwq_pkg::OP_PUSH: begin
                rsp_valid_q <= 1'b1;
                rsp_q       <= '{found: 1'b0, handle: '0, level: '0,
                                 status: lvl_full ? spwq_pkg::ST_FULL : spwq_pkg::ST_OK};
                if (!lvl_full) begin
                  tail[lvl]  <= tail_next;
                  count[lvl] <= count[lvl] + CW'(1);
                end
              end
              spwq_pkg::OP_POP: begin
                if (any) begin
                  head[sel]  <= head_next;
                  count[sel] <= count[sel] - CW'(1);
                  sel_q      <= sel;
                  state      <= S_READ;
                end else begin
                  rsp_valid_q <= 1'b1;
                  rsp_q       <= '{found: 1'b0, handle: '0, level: '0,
                                   status: spwq_pkg::ST_EMPTY};
                end
              end
              default: begin
                rsp_valid_q <= 1'b1;
                rsp_q       <= '{found: 1'b0, handle: '0, level: '0,
                                 status: spwq_pkg::ST_INVALID};
              end
            endcase
          end
        end
        S_READ: begin
          // Store data is back: hand out the popped handle
          rsp_valid_q <= 1'b1;
          rsp_q       <= '{found: 1'b1,
                           handle: rd_wide[spwq_pkg::PORT_HANDLE_W-1:0],
                           level: sel_wide[spwq_pkg::PORT_PRIO_W-1:0],
                           status: spwq_pkg::ST_OK};
          state       <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp_valid = rsp_valid_q;
  assign rsp_data  = rsp_q;

endmodule

`default_nettype wire

>>> rtl/core/strict_priority_work_queue_top.sv
// Strict priority work queue: one FIFO of work handles per priority level,
// QUEUE_DEPTH handles each, held in a single store of NUM_LEVELS x QUEUE_DEPTH
// words. Each request word returns exactly one response word, in order. A valid
// push appends its handle to its level (a priority at or above NUM_LEVELS goes to
// the top level); a push to a full level is dropped with status 2, an invalid
// push returns status 1. A pop returns the oldest handle of the highest non-empty
// level, or status 3 when all levels are empty. A two-word command queue sits
// between the request decoder and the execute unit, and the response sits in an
// output register, so either side may stall. Pushes, invalid pushes and empty pops
// are answered when taken; a pop that finds work waits in a read state for the
// registered read port of the handle store and blocks new commands. No clearing
// pass runs after reset: the per-level counts mark what holds valid data.
`default_nettype none

module strict_priority_work_queue_top #(
  parameter int NUM_LEVELS   = 4,
  parameter int QUEUE_DEPTH  = 16,
  parameter int HANDLE_WIDTH = 32
) (
  input  wire logic   clk,
  input  wire logic   rst,
  spwq_req_if.sink    req,
  spwq_rsp_if.source  rsp
);

  logic                cmd_valid;
  logic                cmd_ready;
  spwq_pkg::spwq_cmd_t cmd;
  logic                rsp_valid;
  spwq_pkg::spwq_rsp_t rsp_data;

  spwq_front #(
    .NUM_LEVELS (NUM_LEVELS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  spwq_back #(
    .NUM_LEVELS   (NUM_LEVELS),
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .HANDLE_WIDTH (HANDLE_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp_data)
  );

  // Drive the response channel from the result register
  assign rsp.valid        = rsp_valid;
  assign rsp.pop_found    = rsp_data.found;
  assign rsp.pop_handle   = rsp_data.handle;
  assign rsp.pop_priority = rsp_data.level;
  assign rsp.status       = rsp_data.status;

endmodule

`default_nettype wire

>>> rtl/core/spwq_checker.sv
`default_nettype none

module spwq_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        rsp_valid,
  input wire logic        rsp_ready,
  input wire logic        pop_found,
  input wire logic [31:0] pop_handle,
  input wire logic [1:0]  pop_priority,
  input wire logic [1:0]  status
);

  // Hold a stalled response word
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(pop_handle) && $stable(status)
      && $stable(pop_found) && $stable(pop_priority))
    else $error("response changed while stalled");

  // No response right after reset
  a_rsp_reset: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid after reset");

  // A found handle always reports ok
  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && pop_found |-> status == spwq_pkg::ST_OK)
    else $error("found pop with error status");

  // A response without a handle carries zero handle and level
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !pop_found |-> pop_handle == 32'd0 && pop_priority == 2'd0)
    else $error("non-pop response carries data");

endmodule

bind strict_priority_work_queue_top spwq_checker u_spwq_checker (
  .clk          (clk),
  .rst          (rst),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .pop_found    (rsp.pop_found),
  .pop_handle   (rsp.pop_handle),
  .pop_priority (rsp.pop_priority),
  .status       (rsp.status)
);

`default_nettype wire
